FILE: sv/gift_wrapping_convex_hull_top_macros.svh
// assertion macros for the convex hull block
`ifndef GIFT_WRAPPING_CONVEX_HULL_TOP_MACROS_SVH
`define GIFT_WRAPPING_CONVEX_HULL_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define GWCH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define GWCH_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GWCH_ASSERT(label, clk, rst_n, prop)
`define GWCH_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: sv/gwch_pkg.sv
// shared constants and types for the convex hull block
`timescale 1ns / 1ps
package gwch_pkg;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 16;
endpackage

FILE: sv/gwch_front.sv
// load side: accepts points and hands them to the queue
`timescale 1ns / 1ps
module gwch_front #(
  parameter int unsigned CoordBits = gwch_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        point_valid_i,
  output logic                        point_ready_o,
  input  logic signed [CoordBits-1:0] point_x_i,
  input  logic signed [CoordBits-1:0] point_y_i,
  input  logic                        last_point_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output logic [2*CoordBits:0]        q_data_o
);
  import gwch_pkg::*;
  // two entry queue
  logic [2*CoordBits:0] mem_q [2];
  logic                 wp_q, rp_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;

  assign point_ready_o = (cnt_q != 2'd2);
  assign push = point_valid_i && point_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {last_point_i, point_y_i, point_x_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: sv/gwch_back.sv
// hull walk: point memory, scan unit and vertex output
`timescale 1ns / 1ps
`include "gift_wrapping_convex_hull_top_macros.svh"
module gwch_back #(
  parameter int unsigned MaxPoints = gwch_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = gwch_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [2*CoordBits:0]        q_data_i,
  output logic                        vertex_valid_o,
  input  logic                        vertex_ready_i,
  output logic signed [CoordBits-1:0] vertex_x_o,
  output logic signed [CoordBits-1:0] vertex_y_o,
  output logic                        last_vertex_o,
  output logic                        walk_error_o
);
  import gwch_pkg::*;
  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned SW = PW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxPoints);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_MIN   = 9'b000000010,
    S_MINW  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_CMP1  = 9'b000010000,
    S_CMP2  = 9'b000100000,
    S_STEP  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_EMITW = 9'b100000000
  } state_e;

  typedef logic signed [CoordBits-1:0] crd_t;

  state_e state_q, state_d;
  logic [2*CoordBits-1:0] pmem [MaxPoints];
  logic [2*CoordBits-1:0] hmem [MaxPoints];
  logic [2*CoordBits-1:0] prd_q, hrd_q;
  logic [CW-1:0] pcnt_q, hcnt_q, idx_q, ecnt_q;
  crd_t sx_q, sy_q, cx_q, cy_q, vx_q, vy_q, px_q, py_q, qx_q, qy_q;
  logic prev_virt_q, have_q, err_q;
  logic signed [PW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [SW-1:0] cr_s, dq_s, dp_s;
  crd_t rx, ry;
  logic out_valid_q, out_last_q, out_err_q;
  crd_t out_x_q, out_y_q;
  logic signed [DW-1:0] qdx, qdy, pdx, pdy;
  logic skip;
  logic [CW-1:0] rd_idx;
  logic min_take, emit_go;
  crd_t min_x, min_y;

  assign rx = prd_q[CoordBits-1:0];
  assign ry = prd_q[2*CoordBits-1:CoordBits];
  assign q_ready_o = (state_q == S_LOAD);
  wire q_fire = q_valid_i && q_ready_o;

  assign qdx = DW'(qx_q) - DW'(cx_q);
  assign qdy = DW'(qy_q) - DW'(cy_q);
  assign pdx = DW'(px_q) - DW'(cx_q);
  assign pdy = DW'(py_q) - DW'(cy_q);
  assign cr_s = SW'(m1_q) - SW'(m2_q);
  assign dq_s = SW'(m3_q);
  assign dp_s = SW'(m4_q);
  assign skip = (!prev_virt_q && rx == vx_q && ry == vy_q) || (rx == cx_q && ry == cy_q);

  // during a compare the read port stays on the entry the scan resumes with
  assign rd_idx = (state_q == S_CMP1 || state_q == S_CMP2) ? idx_q - 1'b1 : idx_q;
  assign min_take = (idx_q == CW'(1)) || (ry < sy_q) || (ry == sy_q && rx < sx_q);
  assign min_x = min_take ? rx : sx_q;
  assign min_y = min_take ? ry : sy_q;
  assign emit_go = (state_q == S_EMITW) && (!out_valid_q || vertex_ready_i);

  // memories: points written on load, read through a register
  always_ff @(posedge clk_i) begin
    if (q_fire && pcnt_q < MaxCnt)
      pmem[pcnt_q[AW-1:0]] <= q_data_i[2*CoordBits-1:0];
    prd_q <= pmem[rd_idx[AW-1:0]];
    if (state_q == S_EMIT) hrd_q <= hmem[ecnt_q[AW-1:0]];
    if (state_q == S_STEP && have_q && !(px_q == sx_q && py_q == sy_q) && hcnt_q < MaxCnt)
      hmem[hcnt_q[AW-1:0]] <= {py_q, px_q};
    // two-step cross product and distance compare
    if (state_q == S_CMP1) begin
      m1_q <= PW'(qdx * pdy);
      m2_q <= PW'(qdy * pdx);
      m3_q <= PW'(qdx * qdx) + PW'(qdy * qdy);
      m4_q <= PW'(pdx * pdx) + PW'(pdy * pdy);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:  if (q_fire && q_data_i[2*CoordBits]) state_d = S_MIN;
      S_MIN:   state_d = S_MINW;
      S_MINW:  state_d = (idx_q == pcnt_q) ? S_SCAN : S_MINW;
      S_SCAN:  state_d = (idx_q == pcnt_q + 1'b1) ? S_STEP : S_SCAN;
      S_CMP1:  state_d = S_CMP2;
      S_CMP2:  state_d = S_SCAN;
      S_STEP:  state_d = S_SCAN;
      S_EMIT:  state_d = S_EMITW;
      S_EMITW: state_d = S_EMITW;
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      pcnt_q <= '0; hcnt_q <= '0; idx_q <= '0; ecnt_q <= '0;
      sx_q <= '0; sy_q <= '0; cx_q <= '0; cy_q <= '0; vx_q <= '0; vy_q <= '0;
      px_q <= '0; py_q <= '0; qx_q <= '0; qy_q <= '0;
      prev_virt_q <= 1'b1; have_q <= 1'b0; err_q <= 1'b0;
      out_valid_q <= 1'b0; out_last_q <= 1'b0; out_err_q <= 1'b0;
      out_x_q <= '0; out_y_q <= '0;
    end else begin
      if (emit_go) out_valid_q <= 1'b1;
      else if (vertex_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (q_fire) begin
            if (pcnt_q < MaxCnt) pcnt_q <= pcnt_q + 1'b1;
            if (q_data_i[2*CoordBits]) idx_q <= '0;
          end
          state_q <= state_d;
        end
        S_MIN: begin
          idx_q <= CW'(1);
          state_q <= S_MINW;
        end
        S_MINW: begin
          // prd_q holds entry idx_q-1
          sx_q <= min_x; sy_q <= min_y;
          if (idx_q == pcnt_q) begin
            // walk start from the lowest point
            idx_q <= '0;
            hcnt_q <= CW'(1);
            prev_virt_q <= 1'b1;
            have_q <= 1'b0;
            err_q <= 1'b0;
            cx_q <= min_x; cy_q <= min_y;
            ecnt_q <= CW'(1);
            state_q <= S_SCAN;
            px_q <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_STEP: begin
          if (!have_q || (px_q == sx_q && py_q == sy_q)) begin
            ecnt_q <= '0; idx_q <= '0;
            state_q <= S_EMIT;
          end else if (hcnt_q >= MaxCnt) begin
            err_q <= 1'b1;
            ecnt_q <= '0; idx_q <= '0;
            state_q <= S_EMIT;
          end else begin
            hcnt_q <= hcnt_q + 1'b1;
            vx_q <= cx_q; vy_q <= cy_q; prev_virt_q <= 1'b0;
            cx_q <= px_q; cy_q <= py_q;
            have_q <= 1'b0; idx_q <= '0; ecnt_q <= CW'(1);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // ecnt_q as a flag: waits out the registered read before data arrives
          if (ecnt_q != '0) begin
            ecnt_q <= '0;
            idx_q <= idx_q + 1'b1;
          end else if (idx_q == pcnt_q + 1'b1) begin
            state_q <= S_STEP;
            idx_q <= '0;
          end else begin
            if (!skip) begin
              if (!have_q) begin
                px_q <= rx; py_q <= ry; have_q <= 1'b1;
              end else begin
                qx_q <= rx; qy_q <= ry;
                state_q <= S_CMP1;
              end
            end
            if (state_q == S_SCAN) idx_q <= idx_q + 1'b1;
          end
        end
        S_CMP1: state_q <= S_CMP2;
        S_CMP2: begin
          if (cr_s > 0 || (cr_s == 0 && dq_s > dp_s)) begin
            px_q <= qx_q; py_q <= qy_q;
          end
          state_q <= S_SCAN;
        end
        S_EMIT: begin
          ecnt_q <= ecnt_q + 1'b1;
          state_q <= S_EMITW;
        end
        S_EMITW: begin
          if (emit_go) begin
            if (ecnt_q == CW'(1)) begin
              out_x_q <= sx_q; out_y_q <= sy_q;
            end else begin
              out_x_q <= hrd_q[CoordBits-1:0];
              out_y_q <= hrd_q[2*CoordBits-1:CoordBits];
            end
            out_err_q <= err_q;
            out_last_q <= (ecnt_q == hcnt_q);
            if (ecnt_q == hcnt_q) begin
              state_q <= S_LOAD;
              pcnt_q <= '0; hcnt_q <= CW'(1); ecnt_q <= '0; idx_q <= '0;
              px_q <= '0; py_q <= '0; have_q <= 1'b0; prev_virt_q <= 1'b1;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign vertex_valid_o = out_valid_q;
  assign vertex_x_o = out_x_q;
  assign vertex_y_o = out_y_q;
  assign last_vertex_o = out_last_q;
  assign walk_error_o = out_err_q;

  `GWCH_ASSERT(a_ready_load, clk_i, rst_ni, q_ready_o |-> state_q == S_LOAD)
  `GWCH_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `GWCH_ASSERT(a_pcnt, clk_i, rst_ni, pcnt_q <= MaxCnt)
  `GWCH_ASSERT(a_hcnt, clk_i, rst_ni, hcnt_q <= MaxCnt)
endmodule

FILE: sv/gift_wrapping_convex_hull_top.sv
// Convex hull by gift wrapping. Points load at one per cycle while the block
// is loading, into an on-chip memory; the point with last_point set starts
// the walk. The walk reads every stored point once per hull vertex through
// the single read port, with a registered cross-product compare (S_CMP1, then
// S_CMP2) for each candidate after the first. Each vertex is then emitted
// through S_EMIT and S_EMITW. While a walk or emission is running, at most
// two new points wait in the input queue and the input then stalls.
`timescale 1ns / 1ps
module gift_wrapping_convex_hull_top #(
  parameter int unsigned MaxPoints = gwch_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = gwch_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        point_valid_i,
  output logic                        point_ready_o,
  input  logic signed [CoordBits-1:0] point_x_i,
  input  logic signed [CoordBits-1:0] point_y_i,
  input  logic                        last_point_i,
  output logic                        vertex_valid_o,
  input  logic                        vertex_ready_i,
  output logic signed [CoordBits-1:0] vertex_x_o,
  output logic signed [CoordBits-1:0] vertex_y_o,
  output logic                        last_vertex_o,
  output logic                        walk_error_o
);
  import gwch_pkg::*;
  logic q_valid, q_ready;
  logic [2*CoordBits:0] q_data;

  gwch_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .point_valid_i, .point_ready_o, .point_x_i, .point_y_i,
    .last_point_i, .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  gwch_back #(.MaxPoints(MaxPoints), .CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .vertex_valid_o, .vertex_ready_i, .vertex_x_o, .vertex_y_o, .last_vertex_o,
    .walk_error_o
  );
endmodule
